// File: hw/rtl/rwcl_pkg.sv
// Shared types and constants for the RIFF/WAVE chunk locator.
package rwcl_pkg;

  // Default width of the byte position counter.
  localparam int unsigned DEF_OFFSET_BITS = 32;

  // Little-endian four-character tags as they appear in an assembled word.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Smallest accepted format chunk body.
  localparam logic [31:0] FMT_MIN_LEN = 32'd14;

  // Byte offset of the first chunk after the RIFF/WAVE header.
  localparam logic [32:0] FIRST_CHUNK = 33'd12;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_RIFF   = 3'd1,
    ST_NOT_WAVE   = 3'd2,
    ST_FMT_SHORT  = 3'd3,
    ST_INCOMPLETE = 3'd4
  } rwcl_status_t;

  // Parser phases, one-hot.
  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_TAG    = 5'b00010,
    PH_LEN    = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_DONE   = 5'b10000
  } rwcl_phase_t;

  // One input byte as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rwcl_item_t;

  // One status result.
  typedef struct packed {
    rwcl_status_t status;
    logic [31:0]  format_offset;
    logic [31:0]  samples_offset;
    logic [31:0]  samples_length;
  } rwcl_result_t;

endpackage

// File: hw/rtl/rwcl_in_if.sv
// Byte stream channel into the chunk locator.
interface rwcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/rwcl_out_if.sv
// Status result channel out of the chunk locator.
interface rwcl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] format_offset;
  logic [31:0] samples_offset;
  logic [31:0] samples_length;

  modport source (output valid, output status, output format_offset,
                  output samples_offset, output samples_length, input ready);
  modport sink   (input valid, input status, input format_offset,
                  input samples_offset, input samples_length, output ready);
endinterface

// File: hw/rtl/rwcl_in_stage.sv
// Input register that holds one byte until the parser consumes it.
module rwcl_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rwcl_pkg::rwcl_item_t in_item,
  output logic                item_valid,
  output rwcl_pkg::rwcl_item_t item,
  input  logic                item_go
);
  import rwcl_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  rwcl_item_t item_r;

  // The register frees up in the same cycle that the parser consumes it.
  assign in_ready   = !valid_r || item_go;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_go) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end
endmodule

// File: hw/rtl/rwcl_parser.sv
// Per-byte header and chunk walk with the parse state registers.
module rwcl_parser #(
  parameter int unsigned OFFSET_BITS = rwcl_pkg::DEF_OFFSET_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  rwcl_pkg::rwcl_item_t  item,
  input  logic                  out_free,
  output logic                  item_go,
  output logic                  res_valid,
  output rwcl_pkg::rwcl_result_t res
);
  import rwcl_pkg::*;

  // State registers.
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [32:0]            riff_end_r, riff_end_nxt;
  rwcl_phase_t            phase_r, phase_nxt;
  logic [31:0]            word_r, word_nxt;
  logic [31:0]            tag_r, tag_nxt;
  logic [32:0]            skip_r, skip_nxt;
  logic                   fmt_seen_r, fmt_seen_nxt;
  logic [OFFSET_BITS-1:0] fmt_start_r, fmt_start_nxt;
  logic [OFFSET_BITS-1:0] data_start_r, data_start_nxt;
  logic [31:0]            data_size_r, data_size_nxt;
  logic                   fin_r, fin_nxt;

  // Step values.
  logic [OFFSET_BITS:0]   after_w;
  logic [OFFSET_BITS-1:0] after_sat;
  logic [31:0]            shifted;
  logic                   em;
  rwcl_status_t           em_status;
  logic                   do_next;
  logic [32:0]            start_w;
  logic [32:0]            body_left;
  logic [32:0]            padded;
  logic                   is_ok;

  // Position of the following byte, raw and saturated.
  assign after_w   = {1'b0, pos_r} + (OFFSET_BITS+1)'(1);
  assign after_sat = (&pos_r) ? pos_r : after_w[OFFSET_BITS-1:0];
  assign shifted   = {item.data_byte, word_r[31:8]};
  assign body_left = skip_r - 33'(skip_r != 33'd0);
  assign padded    = ({1'b0, shifted} + 33'd1) & ~33'd1;

  always_comb begin
    riff_end_nxt   = riff_end_r;
    phase_nxt      = phase_r;
    word_nxt       = word_r;
    tag_nxt        = tag_r;
    skip_nxt       = skip_r;
    fmt_seen_nxt   = fmt_seen_r;
    fmt_start_nxt  = fmt_start_r;
    data_start_nxt = data_start_r;
    data_size_nxt  = data_size_r;
    fin_nxt        = fin_r;
    pos_nxt        = after_sat;
    em             = 1'b0;
    em_status      = ST_OK;
    do_next        = 1'b0;
    start_w        = 33'd0;

    // Walk the header and chunks while no result has gone out for this file.
    if (!fin_r) begin
      word_nxt = shifted;
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == OFFSET_BITS'(3) && shifted != TAG_RIFF) begin
            em        = 1'b1;
            em_status = ST_NOT_RIFF;
          end else if (pos_r == OFFSET_BITS'(7)) begin
            riff_end_nxt = 33'd8 + {1'b0, shifted};
          end else if (pos_r == OFFSET_BITS'(11)) begin
            if (shifted != TAG_WAVE) begin
              em        = 1'b1;
              em_status = ST_NOT_WAVE;
            end else begin
              do_next = 1'b1;
              start_w = FIRST_CHUNK;
            end
          end
        end
        PH_TAG: begin
          skip_nxt = {30'd0, skip_r[2:0] - 3'd1};
          if (skip_r[2:0] == 3'd1) begin
            tag_nxt   = shifted;
            phase_nxt = PH_LEN;
            skip_nxt  = 33'd4;
          end
        end
        PH_LEN: begin
          skip_nxt = {30'd0, skip_r[2:0] - 3'd1};
          if (skip_r[2:0] == 3'd1) begin
            // Chunk header complete: record fmt or data, then skip the body.
            if (tag_r == TAG_FMT && !fmt_seen_r) begin
              if (shifted < FMT_MIN_LEN) begin
                em        = 1'b1;
                em_status = ST_FMT_SHORT;
              end else begin
                fmt_seen_nxt  = 1'b1;
                fmt_start_nxt = after_sat;
                if (data_size_r != 32'd0) begin
                  em        = 1'b1;
                  em_status = ST_OK;
                end
              end
            end else if (tag_r == TAG_DATA && data_size_r == 32'd0) begin
              data_start_nxt = after_sat;
              data_size_nxt  = shifted;
              if (fmt_seen_r) begin
                em        = 1'b1;
                em_status = ST_OK;
              end
            end
            if (!em) begin
              skip_nxt = padded;
              if (padded == 33'd0) begin
                do_next = 1'b1;
                start_w = 33'(after_sat);
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          skip_nxt = body_left;
          if (body_left == 33'd0) begin
            do_next = 1'b1;
            start_w = 33'(after_w);
          end
        end
        default: begin
        end
      endcase

      // Start the next chunk header, or close the walk at the region end.
      if (do_next) begin
        if (start_w >= riff_end_r) begin
          em        = 1'b1;
          em_status = ST_INCOMPLETE;
        end else begin
          phase_nxt = PH_TAG;
          skip_nxt  = 33'd4;
        end
      end
    end

    // End of stream before any result.
    if (item.last_byte && !fin_r && !em) begin
      em        = 1'b1;
      em_status = ST_INCOMPLETE;
    end
    if (em) begin
      fin_nxt   = 1'b1;
      phase_nxt = PH_DONE;
    end
  end

  // Result fields come from the values after this byte's updates.
  assign is_ok               = (em_status == ST_OK);
  assign res.status          = em_status;
  assign res.format_offset   = is_ok ? 32'(fmt_start_nxt) : 32'd0;
  assign res.samples_offset  = is_ok ? 32'(data_start_nxt) : 32'd0;
  assign res.samples_length  = is_ok ? data_size_nxt : 32'd0;

  // A byte with a result waits for a free output register.
  assign item_go   = item_valid && (!em || out_free);
  assign res_valid = item_go && em;

  // State update; the last byte of a file returns everything to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (item_go && item.last_byte)) begin
      pos_r        <= '0;
      riff_end_r   <= '0;
      phase_r      <= PH_HEADER;
      word_r       <= '0;
      tag_r        <= '0;
      skip_r       <= '0;
      fmt_seen_r   <= 1'b0;
      fmt_start_r  <= '0;
      data_start_r <= '0;
      data_size_r  <= '0;
      fin_r        <= 1'b0;
    end else if (item_go) begin
      pos_r        <= pos_nxt;
      riff_end_r   <= riff_end_nxt;
      phase_r      <= phase_nxt;
      word_r       <= word_nxt;
      tag_r        <= tag_nxt;
      skip_r       <= skip_nxt;
      fmt_seen_r   <= fmt_seen_nxt;
      fmt_start_r  <= fmt_start_nxt;
      data_start_r <= data_start_nxt;
      data_size_r  <= data_size_nxt;
      fin_r        <= fin_nxt;
    end
  end
endmodule

// File: hw/rtl/rwcl_out_stage.sv
// Result register that holds a status until the receiver takes it.
module rwcl_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  rwcl_pkg::rwcl_result_t res,
  output logic                   out_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rwcl_pkg::rwcl_result_t out_res
);
  import rwcl_pkg::*;

  logic         valid_r;
  logic         valid_nxt;
  rwcl_result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end
endmodule

// File: hw/rtl/riff_wave_chunk_locator_unit.sv
// Top level of the RIFF/WAVE chunk locator.
//
// The in_chan channel carries a wave file one byte per transfer, with
// last_byte set on the final byte; the next byte begins a new file.
// The out_chan channel carries exactly one status result per file: ok with
// the format body offset, data body offset and data length, or an error
// code (not RIFF, not WAVE, format too short, incomplete) with zero fields.
// A byte is taken in by an input register and then processed by the
// parser, whose result lands in the output register.
// Throughput is one byte per clock unless a byte with a result waits for
// the output register; the parser state registers feed back on themselves.
// When the receiver stalls, bytes that cause no result keep flowing; a
// byte that would cause a second result waits in the input register, and
// in_chan.ready falls once that register is held.
// Reset (rst_n low at a clock edge) empties both registers and returns the
// parser to the start of a file. Bytes after a file's result are ignored
// until its last byte.
module riff_wave_chunk_locator_unit #(
  parameter int unsigned OFFSET_BITS = rwcl_pkg::DEF_OFFSET_BITS
) (
  input logic          clk,
  input logic          rst_n,
  rwcl_in_if.sink      in_chan,
  rwcl_out_if.source   out_chan
);
  import rwcl_pkg::*;

  rwcl_item_t   in_item;
  rwcl_item_t   item;
  logic         item_valid;
  logic         item_go;
  logic         out_free;
  logic         res_valid;
  rwcl_result_t res;
  rwcl_result_t out_res;

  assign in_item.data_byte = in_chan.data_byte;
  assign in_item.last_byte = in_chan.last_byte;

  // Input register.
  rwcl_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_go    (item_go)
  );

  // Header and chunk walk.
  rwcl_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .item_go    (item_go),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register.
  rwcl_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.status         = out_res.status;
  assign out_chan.format_offset  = out_res.format_offset;
  assign out_chan.samples_offset = out_res.samples_offset;
  assign out_chan.samples_length = out_res.samples_length;
endmodule

// File: hw/rtl/rwcl_checker.sv
// Port-level checks for the chunk locator and their binding to the top level.
module rwcl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] format_offset,
  input logic [31:0] samples_offset,
  input logic [31:0] samples_length
);
  import rwcl_pkg::*;

  // A result stays offered until it is transferred.
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // A stalled result keeps its payload.
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(status) && $stable(format_offset)
      && $stable(samples_offset) && $stable(samples_length))
    else $error("stalled result changed");

  // Only the five defined status codes are produced.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= ST_INCOMPLETE)
    else $error("undefined status code");

  // Error results carry no offsets or length.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> format_offset == 32'd0
      && samples_offset == 32'd0 && samples_length == 32'd0)
    else $error("error result with nonzero fields");

  // Both chunk bodies lie past the file header and their own chunk header.
  a_ok_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_OK |-> format_offset >= 32'd20
      && samples_offset >= 32'd20 && format_offset != samples_offset)
    else $error("ok result with impossible offsets");
endmodule

bind riff_wave_chunk_locator_unit rwcl_checker u_rwcl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .status         (out_chan.status),
  .format_offset  (out_chan.format_offset),
  .samples_offset (out_chan.samples_offset),
  .samples_length (out_chan.samples_length)
);
